// ----- rtl/anbx_pkg.sv -----
`default_nettype none
package anbx_pkg;

  typedef enum logic {
    CODEC_H264 = 1'b0,
    CODEC_HEVC = 1'b1
  } codec_e;

  // register word index on the configuration port
  localparam logic REG_CODEC = 1'b0;

  localparam logic [22:0] COUNT_CAP = 23'd4194304;

  // result queue
  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = 2;

  // h.264 nal types
  localparam logic [5:0] H264_VCL_LO = 6'd1;
  localparam logic [5:0] H264_VCL_HI = 6'd5;
  localparam logic [5:0] H264_IDR    = 6'd5;
  localparam logic [5:0] H264_SPS    = 6'd7;
  localparam logic [5:0] H264_PPS    = 6'd8;

  // hevc nal types
  localparam logic [5:0] HEVC_VCL_HI  = 6'd31;
  localparam logic [5:0] HEVC_IRAP_LO = 6'd16;
  localparam logic [5:0] HEVC_IRAP_HI = 6'd21;
  localparam logic [5:0] HEVC_VPS     = 6'd32;
  localparam logic [5:0] HEVC_SPS     = 6'd33;
  localparam logic [5:0] HEVC_PPS     = 6'd34;

  typedef struct packed {
    logic pskey;
    logic key;
    logic vps;
    logic pps;
    logic sps;
    logic video;
  } flags_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] nal_offset;
    logic [23:0] nal_length;
    logic [5:0]  nal_kind;
    logic        is_annexb;
    logic [22:0] nal_total;
    logic        has_video_slice;
    logic        has_param_sets;
    logic        has_keyframe;
    logic        self_contained_key;
    logic        decodable_here;
    logic        last_result;
  } result_t;

  // up to two results per byte, slot 0 first
  typedef struct packed {
    logic [1:0]    vld;
    result_t [1:0] item;
  } push_t;

  function automatic logic [5:0] nal_header_type(codec_e codec, logic [7:0] hdr);
    logic [5:0] t;
    if (codec == CODEC_H264) begin
      t = {1'b0, hdr[4:0]};
    end else begin
      t = hdr[6:1];
    end
    return t;
  endfunction

  function automatic logic params_complete(codec_e codec, flags_t f);
    logic ok;
    if (codec == CODEC_H264) begin
      ok = f.sps && f.pps;
    end else begin
      ok = f.vps && f.sps && f.pps;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/anbx_parse.sv -----
`default_nettype none
module anbx_parse #(
  parameter logic [23:0] PosCap = 24'hFFFFFF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [7:0]       stream_byte_i,
  input  wire logic             unit_end_i,
  input  anbx_pkg::codec_e      codec_i,
  output anbx_pkg::push_t       push_o
);
  import anbx_pkg::*;

  logic [23:0] pos_q, pos_d;
  logic [1:0]  zr_q, zr_d;
  logic        in_nal_q, in_nal_d;
  logic [24:0] cs_q, cs_d;
  logic [5:0]  hdr_q, hdr_d;
  logic [22:0] cnt_q, cnt_d;
  flags_t      flags_q, flags_d;

  logic        start;
  logic [24:0] p25;
  logic        cap_hdr;
  logic [5:0]  hdr_eff;
  logic [24:0] cend;
  logic [24:0] len;
  logic        close_do;
  logic        emit;
  logic        key_type;
  flags_t      fl;
  logic [22:0] cnt_n;
  logic        key;
  logic        self_key;
  result_t     desc;
  result_t     rep;

  always_comb begin
    start    = (stream_byte_i == 8'h01) && (zr_q >= 2'd2);
    p25      = {1'b0, pos_q};
    cap_hdr  = !start && in_nal_q && (p25 == cs_q);
    hdr_eff  = cap_hdr ? nal_header_type(codec_i, stream_byte_i) : hdr_q;
    // a start code closes at its first zero, the unit end after this byte
    cend     = start ? (p25 - 25'(zr_q)) : (p25 + 25'd1);
    close_do = in_nal_q && (start || unit_end_i);
    len      = (cend > cs_q) ? (cend - cs_q) : '0;
    emit     = close_do && (len != '0);

    fl = flags_q;
    key_type = 1'b0;
    if (codec_i == CODEC_H264) begin
      key_type = (hdr_eff == H264_IDR);
    end else begin
      key_type = (hdr_eff >= HEVC_IRAP_LO) && (hdr_eff <= HEVC_IRAP_HI);
    end
    if (emit) begin
      if (codec_i == CODEC_H264) begin
        if (hdr_eff >= H264_VCL_LO && hdr_eff <= H264_VCL_HI) fl.video = 1'b1;
        if (hdr_eff == H264_SPS) fl.sps = 1'b1;
        if (hdr_eff == H264_PPS) fl.pps = 1'b1;
      end else begin
        if (hdr_eff <= HEVC_VCL_HI) fl.video = 1'b1;
        if (hdr_eff == HEVC_VPS) fl.vps = 1'b1;
        if (hdr_eff == HEVC_SPS) fl.sps = 1'b1;
        if (hdr_eff == HEVC_PPS) fl.pps = 1'b1;
      end
      if (key_type) begin
        if (!fl.key && params_complete(codec_i, fl)) fl.pskey = 1'b1;
        fl.key = 1'b1;
      end
    end
    cnt_n = (emit && (cnt_q < COUNT_CAP)) ? (cnt_q + 23'd1) : cnt_q;

    desc            = '0;
    desc.nal_offset = cs_q[23:0];
    desc.nal_length = len[23:0];
    desc.nal_kind   = hdr_eff;

    key      = fl.key;
    self_key = fl.key && fl.pskey;
    rep             = '0;
    rep.result_kind = 1'b1;
    rep.last_result = 1'b1;
    if (cnt_n != '0) begin
      rep.is_annexb          = 1'b1;
      rep.nal_total          = cnt_n;
      rep.has_video_slice    = fl.video;
      rep.has_param_sets     = params_complete(codec_i, fl);
      rep.has_keyframe       = key;
      rep.self_contained_key = self_key;
      rep.decodable_here     = !key || self_key;
    end

    push_o.vld[0]  = en_i && (emit || unit_end_i);
    push_o.vld[1]  = en_i && emit && unit_end_i;
    push_o.item[0] = emit ? desc : rep;
    push_o.item[1] = rep;
  end

  always_comb begin
    pos_d    = pos_q;
    zr_d     = zr_q;
    in_nal_d = in_nal_q;
    cs_d     = cs_q;
    hdr_d    = hdr_q;
    cnt_d    = cnt_q;
    flags_d  = flags_q;
    if (en_i) begin
      if (unit_end_i) begin
        pos_d    = '0;
        zr_d     = '0;
        in_nal_d = 1'b0;
        cs_d     = '0;
        hdr_d    = '0;
        cnt_d    = '0;
        flags_d  = '0;
      end else begin
        pos_d = (pos_q < PosCap) ? (pos_q + 24'd1) : pos_q;
        if (start) begin
          zr_d     = '0;
          in_nal_d = 1'b1;
          cs_d     = p25 + 25'd1;
        end else if (stream_byte_i == 8'h00) begin
          zr_d = (zr_q == 2'd3) ? zr_q : (zr_q + 2'd1);
        end else begin
          zr_d = '0;
        end
        hdr_d   = hdr_eff;
        cnt_d   = cnt_n;
        flags_d = fl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      zr_q     <= '0;
      in_nal_q <= 1'b0;
      cs_q     <= '0;
      hdr_q    <= '0;
      cnt_q    <= '0;
      flags_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      zr_q     <= zr_d;
      in_nal_q <= in_nal_d;
      cs_q     <= cs_d;
      hdr_q    <= hdr_d;
      cnt_q    <= cnt_d;
      flags_q  <= flags_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/anbx_resq.sv -----
`default_nettype none
module anbx_resq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  anbx_pkg::push_t                    push_i,
  input  wire logic                          pop_i,
  output anbx_pkg::result_t                  head_o,
  output logic                               nempty_o,
  output logic [anbx_pkg::RESQ_AW:0]         free_o
);
  import anbx_pkg::*;

  logic [RESQ_AW-1:0] wp_q, wp_d;
  logic [RESQ_AW-1:0] rp_q, rp_d;
  logic [RESQ_AW:0]   cnt_q, cnt_d;
  logic [RESQ_AW-1:0] wp_nx;
  logic [RESQ_AW:0]   n_push;
  result_t            mem_q [RESQ_DEPTH];

  always_comb begin
    wp_nx  = wp_q + RESQ_AW'(1);
    n_push = (RESQ_AW+1)'(push_i.vld[0]) + (RESQ_AW+1)'(push_i.vld[1]);
    wp_d   = wp_q + n_push[RESQ_AW-1:0];
    rp_d   = pop_i ? (rp_q + RESQ_AW'(1)) : rp_q;
    cnt_d  = cnt_q + n_push - (RESQ_AW+1)'(pop_i);
  end

  assign head_o   = mem_q[rp_q];
  assign nempty_o = (cnt_q != '0);
  assign free_o   = (RESQ_AW+1)'(RESQ_DEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      mem_q[wp_q] <= push_i.item[0];
    end
    if (push_i.vld[1]) begin
      mem_q[wp_nx] <= push_i.item[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/annexb_nal_splitter_inspector.sv -----
`default_nettype none
// Annex-B NAL splitter and access-unit inspector. One byte of the unit is taken
// per transfer, one every cycle in steady state: a byte is held in the input
// register, where a single pass of zero-run and flag logic closes any NAL and
// writes its descriptor, and on the marked last byte also the unit report,
// into a four-entry result queue that drives the output. The input stalls
// only when the queue has fewer than two free entries. Descriptors come in
// stream order, the report last. codec_select (byte address 0) picks H.264
// or HEVC header rules; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module annexb_nal_splitter_inspector #(
  parameter longint unsigned MAX_UNIT_BYTES = 64'd16777216
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  input  wire logic        unit_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [23:0]      nal_offset_o,
  output logic [23:0]      nal_length_o,
  output logic [5:0]       nal_kind_o,
  output logic             is_annexb_o,
  output logic [22:0]      nal_total_o,
  output logic             has_video_slice_o,
  output logic             has_param_sets_o,
  output logic             has_keyframe_o,
  output logic             self_contained_key_o,
  output logic             decodable_here_o,
  output logic             last_result_o
);
  import anbx_pkg::*;

  localparam logic [23:0] POS_CAP = (MAX_UNIT_BYTES < 64'd16777216) ?
                                    24'(MAX_UNIT_BYTES - 64'd1) : 24'hFFFFFF;

  codec_e           codec_q, codec_d;
  logic             stg_vld_q, stg_vld_d;
  logic [7:0]       stg_byte_q;
  logic             stg_end_q;
  logic             advance;
  logic             in_xfer;
  logic             cfg_wr;
  push_t            push;
  result_t          head;
  logic             q_nempty;
  logic [RESQ_AW:0] q_free;

  // configuration port
  always_comb begin
    cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_CODEC);
    codec_d = cfg_wr ? codec_e'(pwdata[0]) : codec_q;
    pready  = 1'b1;
    prdata  = '0;
    if (paddr[2] == REG_CODEC) begin
      prdata = {31'd0, codec_q};
    end
  end

  // the staged byte goes through once the queue can take both results
  assign advance    = stg_vld_q && (q_free >= (RESQ_AW+1)'(2));
  assign in_ready_o = !stg_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign stg_vld_d  = in_xfer || (stg_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q   <= CODEC_H264;
      stg_vld_q <= 1'b0;
    end else begin
      codec_q   <= codec_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_byte_q <= stream_byte_i;
      stg_end_q  <= unit_end_i;
    end
  end

  anbx_parse #(
    .PosCap (POS_CAP)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .stream_byte_i (stg_byte_q),
    .unit_end_i    (stg_end_q),
    .codec_i       (codec_q),
    .push_o        (push)
  );

  anbx_resq u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (out_valid_o && out_ready_i),
    .head_o   (head),
    .nempty_o (q_nempty),
    .free_o   (q_free)
  );

  assign out_valid_o          = q_nempty;
  assign result_kind_o        = head.result_kind;
  assign nal_offset_o         = head.nal_offset;
  assign nal_length_o         = head.nal_length;
  assign nal_kind_o           = head.nal_kind;
  assign is_annexb_o          = head.is_annexb;
  assign nal_total_o          = head.nal_total;
  assign has_video_slice_o    = head.has_video_slice;
  assign has_param_sets_o     = head.has_param_sets;
  assign has_keyframe_o       = head.has_keyframe;
  assign self_contained_key_o = head.self_contained_key;
  assign decodable_here_o     = head.decodable_here;
  assign last_result_o        = head.last_result;

endmodule
`default_nettype wire

// ----- verif/annexb_nal_splitter_inspector_tb.sv -----
module annexb_nal_splitter_inspector_tb;
  import anbx_pkg::*;

  localparam logic [23:0] POS_CAP       = 24'hFFFFFF;
  localparam logic [2:0]  CODEC_ADDR    = 3'(4 * REG_CODEC);
  localparam int          SETTLE_CYCLES = 4;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          RANDOM_BYTES  = 600;
  localparam int          PHASES        = 5;

  class nal_tracker;
    codec_e      codec;
    logic [23:0] pos;
    logic [1:0]  zrun;
    logic        in_nal;
    logic [24:0] start;
    logic [5:0]  hdr_type;
    logic [22:0] nal_count;
    flags_t      seen;
    result_t     pending_results[$];
    int          errors;

    function new();
      codec  = CODEC_H264;
      errors = 0;
      clear_unit();
    endfunction

    function void clear_unit();
      pos       = '0;
      zrun      = '0;
      in_nal    = 1'b0;
      start     = '0;
      hdr_type  = '0;
      nal_count = '0;
      seen      = '0;
    endfunction

    function void queue_result(result_t r);
      pending_results = {pending_results, r};
    endfunction

    function logic params_ok(flags_t f);
      if (codec == CODEC_H264) begin
        return f.sps && f.pps;
      end
      return f.vps && f.sps && f.pps;
    endfunction

    function void close_nal(logic [24:0] stop);
      logic [24:0] len;
      result_t     r;
      in_nal = 1'b0;
      len = (stop > start) ? stop - start : '0;
      if (len == '0) return;
      r = '0;
      r.nal_offset = start[23:0];
      r.nal_length = len[23:0];
      r.nal_kind   = hdr_type;
      queue_result(r);
      if (nal_count < COUNT_CAP) nal_count++;
      if (codec == CODEC_H264) begin
        if (hdr_type >= H264_VCL_LO && hdr_type <= H264_VCL_HI) seen.video = 1'b1;
        if (hdr_type == H264_SPS) seen.sps = 1'b1;
        if (hdr_type == H264_PPS) seen.pps = 1'b1;
      end else begin
        if (hdr_type <= HEVC_VCL_HI) seen.video = 1'b1;
        if (hdr_type == HEVC_VPS) seen.vps = 1'b1;
        if (hdr_type == HEVC_SPS) seen.sps = 1'b1;
        if (hdr_type == HEVC_PPS) seen.pps = 1'b1;
      end
      if ((codec == CODEC_H264) ? (hdr_type == H264_IDR)
                                : (hdr_type >= HEVC_IRAP_LO && hdr_type <= HEVC_IRAP_HI)) begin
        // only the first keyframe decides self-containment
        if (!seen.key && params_ok(seen)) seen.pskey = 1'b1;
        seen.key = 1'b1;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [24:0] p;
      result_t     r;
      p = {1'b0, pos};
      if (b == 8'h01 && zrun >= 2'd2) begin
        // zeros beyond the start code's own stay in the previous nal
        if (in_nal) close_nal(p - zrun);
        in_nal = 1'b1;
        start  = p + 25'd1;
        zrun   = '0;
      end else begin
        if (in_nal && p == start) begin
          hdr_type = (codec == CODEC_H264) ? {1'b0, b[4:0]} : b[6:1];
        end
        if (b == 8'h00) begin
          if (zrun != 2'd3) zrun++;
        end else begin
          zrun = '0;
        end
      end
      if (last) begin
        if (in_nal) close_nal(p + 25'd1);
        r = '0;
        r.result_kind = 1'b1;
        r.last_result = 1'b1;
        if (nal_count != '0) begin
          r.is_annexb          = 1'b1;
          r.nal_total          = nal_count;
          r.has_video_slice    = seen.video;
          r.has_param_sets     = params_ok(seen);
          r.has_keyframe       = seen.key;
          r.self_contained_key = seen.key && seen.pskey;
          r.decodable_here     = !seen.key || seen.pskey;
        end
        queue_result(r);
        clear_unit();
      end else if (pos < POS_CAP) begin
        pos++;
      end
    endfunction

    function void cmp(string name, logic [23:0] e, logic [23:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void match_result(result_t a);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp("result_kind", e.result_kind, a.result_kind);
      cmp("nal_offset", e.nal_offset, a.nal_offset);
      cmp("nal_length", e.nal_length, a.nal_length);
      cmp("nal_kind", e.nal_kind, a.nal_kind);
      cmp("is_annexb", e.is_annexb, a.is_annexb);
      cmp("nal_total", e.nal_total, a.nal_total);
      cmp("has_video_slice", e.has_video_slice, a.has_video_slice);
      cmp("has_param_sets", e.has_param_sets, a.has_param_sets);
      cmp("has_keyframe", e.has_keyframe, a.has_keyframe);
      cmp("self_contained_key", e.self_contained_key, a.self_contained_key);
      cmp("decodable_here", e.decodable_here, a.decodable_here);
      cmp("last_result", e.last_result, a.last_result);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i;
  logic        unit_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [23:0] nal_offset_o;
  logic [23:0] nal_length_o;
  logic [5:0]  nal_kind_o;
  logic        is_annexb_o;
  logic [22:0] nal_total_o;
  logic        has_video_slice_o;
  logic        has_param_sets_o;
  logic        has_keyframe_o;
  logic        self_contained_key_o;
  logic        decodable_here_o;
  logic        last_result_o;

  nal_tracker  tracker;
  logic [7:0]  unit_q[$];
  logic        quiet;
  int          bytes_sent;
  int          stall_cycles;

  annexb_nal_splitter_inspector uut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .stream_byte_i, .unit_end_i,
    .out_valid_o, .out_ready_i,
    .result_kind_o, .nal_offset_o, .nal_length_o, .nal_kind_o,
    .is_annexb_o, .nal_total_o, .has_video_slice_o, .has_param_sets_o,
    .has_keyframe_o, .self_contained_key_o, .decodable_here_o, .last_result_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.take_byte(stream_byte_i, unit_end_i);
      if (out_valid_o && out_ready_i) begin
        tracker.match_result(result_t'({result_kind_o, nal_offset_o, nal_length_o,
          nal_kind_o, is_annexb_o, nal_total_o, has_video_slice_o, has_param_sets_o,
          has_keyframe_o, self_contained_key_o, decodable_here_o, last_result_o}));
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic wait_results_done();
    // let the last input transfer reach the tracker first
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_codec(input codec_e c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CODEC_ADDR;
    pwdata  <= {31'b0, c};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.codec = c;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, c}) begin
      $error("codec_select readback: expected %0d, got %0d", c, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    unit_end_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_unit_q();
    for (int i = 0; i < unit_q.size(); i++) begin
      send_byte(unit_q[i], i == unit_q.size() - 1);
    end
    unit_q = {};
  endtask

  function automatic void add_byte(input logic [7:0] b);
    unit_q = {unit_q, b};
  endfunction

  function automatic logic [5:0] pick_type(codec_e c, int idx, logic ordered);
    logic [5:0] t;
    t = 6'($urandom_range(63));
    if (c == CODEC_H264) begin
      if (ordered) begin
        case (idx)
          0:       t = H264_SPS;
          1:       t = H264_PPS;
          2:       t = H264_IDR;
          default: t = H264_VCL_LO;
        endcase
      end else begin
        case ($urandom_range(4))
          0: t = H264_SPS;
          1: t = H264_PPS;
          2: t = H264_IDR;
          3: t = 6'($urandom_range(H264_VCL_LO, H264_VCL_HI));
          default: ;
        endcase
      end
    end else begin
      if (ordered) begin
        case (idx)
          0:       t = HEVC_VPS;
          1:       t = HEVC_SPS;
          2:       t = HEVC_PPS;
          3:       t = 6'($urandom_range(HEVC_IRAP_LO, HEVC_IRAP_HI));
          default: t = 6'($urandom_range(HEVC_IRAP_LO - 1));
        endcase
      end else begin
        case ($urandom_range(5))
          0: t = HEVC_VPS;
          1: t = HEVC_SPS;
          2: t = HEVC_PPS;
          3: t = 6'($urandom_range(HEVC_IRAP_LO, HEVC_IRAP_HI));
          4: t = 6'($urandom_range(HEVC_VCL_HI));
          default: ;
        endcase
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] header_for(codec_e c, logic [5:0] t);
    logic [7:0] r;
    r = 8'($urandom);
    return (c == CODEC_H264) ? {r[7:5], t[4:0]} : {r[7], t, r[0]};
  endfunction

  task automatic send_random_unit();
    int   kind;
    int   nals;
    int   zeros;
    logic ordered;
    kind = $urandom_range(9);
    if (kind < 2) begin
      // noise, biased towards zeros and ones
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(3))
          0, 1:    add_byte(8'h00);
          2:       add_byte(8'h01);
          default: add_byte(8'($urandom));
        endcase
      end
    end else begin
      ordered = (kind >= 6);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
      nals = $urandom_range(1, 5);
      for (int i = 0; i < nals; i++) begin
        zeros = ($urandom_range(3) == 0) ? 3 : 2;
        if ($urandom_range(9) == 0) zeros = $urandom_range(4, 6);
        repeat (zeros) add_byte(8'h00);
        add_byte(8'h01);
        if ($urandom_range(9) == 0) continue;
        add_byte(header_for(tracker.codec, pick_type(tracker.codec, i, ordered)));
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
      end
      // a start code as the very last bytes
      if ($urandom_range(7) == 0) add_byte(8'h00);
      if (unit_q[unit_q.size() - 1] == 8'h00 && $urandom_range(1) == 0) begin
        add_byte(8'h00);
        add_byte(8'h01);
      end
    end
    send_unit_q();
    if ($urandom_range(9) == 0) begin
      in_valid_i <= 1'b0;
      wait_results_done();
    end
  endtask

  initial begin
    codec_e c;
    tracker       = new();
    quiet         = 1'b0;
    bytes_sent    = 0;
    stall_cycles  = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    stream_byte_i <= '0;
    unit_end_i    <= 1'b0;
    out_ready_i   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset codec: leading garbage, 4-byte code, long zero run,
    // empty nal, start code on the last byte
    unit_q = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
               8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80, 8'h00,
               8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_unit_q();
    // unit with no start code at all
    unit_q = '{8'h00};
    send_unit_q();
    // start code immediately followed by the end of the unit
    unit_q = '{8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h01};
    send_unit_q();
    in_valid_i <= 1'b0;
    wait_results_done();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 2:    c = CODEC_HEVC;
        1, 3:    c = CODEC_H264;
        default: c = codec_e'($urandom_range(1));
      endcase
      write_codec(c);
      quiet = (ph == 2);
      while (bytes_sent < 30 + (ph + 1) * RANDOM_BYTES / PHASES) send_random_unit();
      in_valid_i <= 1'b0;
      wait_results_done();
    end

    wait_results_done();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/anbx_pkg.sv
rtl/anbx_parse.sv
rtl/anbx_resq.sv
rtl/annexb_nal_splitter_inspector.sv
verif/annexb_nal_splitter_inspector_tb.sv
